// File: rtl/core/tcr_pkg.sv
// Shared types and constants of the tachometer capture and RPM block.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package tcr_pkg;

   localparam int COUNTER_WIDTH   = 16;
   localparam int NUM_CHANNELS    = 8;
   localparam int CHANNEL_WIDTH   = 3;
   localparam int CMD_WIDTH       = 2;
   localparam int STATUS_WIDTH    = 2;
   localparam int PRESCALE_WIDTH  = 8;
   localparam int CLOCK_HZ_WIDTH  = 27;
   localparam int PULSES_WIDTH    = 8;
   localparam int RPM_WIDTH       = 32;
   localparam int RPM_SECONDS     = 60;
   localparam int NUM_WIDTH       = CLOCK_HZ_WIDTH + 6;
   localparam int DEN_WIDTH       = PULSES_WIDTH + COUNTER_WIDTH;
   localparam int STEP_WIDTH      = $clog2(NUM_WIDTH + 1);
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = CLOCK_HZ_WIDTH;

   // Commands carried by an input transfer.
   localparam logic [CMD_WIDTH-1:0] CMD_TICK   = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_FETCH  = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_READ   = 2'd2;
   localparam logic [CMD_WIDTH-1:0] CMD_UNUSED = 2'd3;

   // Result status codes.
   localparam logic [STATUS_WIDTH-1:0] ST_OK            = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_NOT_READY     = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_NO_EDGE       = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] ST_WRONG_CHANNEL = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRESCALE_DIVIDE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SAMPLE_CLOCK_HZ = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PULSES_PER_TURN = 2'd2;

   localparam logic [COUNTER_WIDTH-1:0] CNT_ALL_ONES = {COUNTER_WIDTH{1'b1}};

   typedef logic [COUNTER_WIDTH-1:0] count_type;

   // One queued result job handed from the front to the back.
   typedef struct packed {
      logic [STATUS_WIDTH-1:0] status;
      logic                    divide;
      count_type               span;
   } job_type;

endpackage

`default_nettype wire

// File: rtl/core/tcr_front.sv
// Front part: accepts transfers, runs the capture counter and classifies fetch and read.
// Depends on tcr_pkg; feeds result jobs into tcr_queue.
`default_nettype none

module tcr_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [tcr_pkg::CMD_WIDTH-1:0]        req_command,
   input  wire logic                                 req_pin_level,
   input  wire logic [tcr_pkg::CHANNEL_WIDTH-1:0]    req_channel,
   input  wire logic [tcr_pkg::PRESCALE_WIDTH-1:0]   prescale_divide,
   input  wire logic                                 queue_full,
   output logic                                      push,
   output tcr_pkg::job_type                          push_job
);
   import tcr_pkg::*;

   localparam logic [CHANNEL_WIDTH:0] NUM_CH_VAL = (CHANNEL_WIDTH + 1)'(NUM_CHANNELS);

   logic [PRESCALE_WIDTH-1:0] prescale_count_ff, prescale_count_in;
   count_type                 down_counter_ff, down_counter_in;
   count_type                 capture_ff, capture_in;
   logic                      previous_pin_ff, previous_pin_in;
   logic                      captured_ff, captured_in;
   logic                      underflow_ff, underflow_in;
   count_type                 saved_span_ff, saved_span_in;
   logic [CHANNEL_WIDTH-1:0]  channel_ff, channel_in;

   logic                      accept;
   logic [PRESCALE_WIDTH-1:0] divide_eff;
   logic [PRESCALE_WIDTH-1:0] prescale_next;

   assign req_stall     = queue_full;
   assign accept        = req_valid && !queue_full;
   assign divide_eff    = (prescale_divide == '0) ? PRESCALE_WIDTH'(1) : prescale_divide;
   assign prescale_next = prescale_count_ff + PRESCALE_WIDTH'(1);

   always_comb begin
      prescale_count_in = prescale_count_ff;
      down_counter_in   = down_counter_ff;
      capture_in        = capture_ff;
      previous_pin_in   = previous_pin_ff;
      captured_in       = captured_ff;
      underflow_in      = underflow_ff;
      saved_span_in     = saved_span_ff;
      channel_in        = channel_ff;
      push              = 1'b0;
      push_job          = '0;
      if (accept) begin
         unique case (req_command)
            CMD_TICK: begin
               if (previous_pin_ff && !req_pin_level) begin
                  capture_in      = down_counter_ff;
                  down_counter_in = CNT_ALL_ONES;
                  captured_in     = 1'b1;
               end else begin
                  prescale_count_in = prescale_next;
                  if (prescale_next >= divide_eff) begin
                     prescale_count_in = '0;
                     if (down_counter_ff == '0) begin
                        underflow_in    = 1'b1;
                        down_counter_in = CNT_ALL_ONES;
                     end else begin
                        down_counter_in = down_counter_ff - COUNTER_WIDTH'(1);
                     end
                  end
               end
               previous_pin_in = req_pin_level;
            end
            CMD_FETCH: begin
               push = 1'b1;
               if ({1'b0, req_channel} >= NUM_CH_VAL) begin
                  push_job.status = ST_WRONG_CHANNEL;
               end else if (req_channel != channel_ff) begin
                  // Switching channels restarts the capture unit.
                  down_counter_in   = CNT_ALL_ONES;
                  capture_in        = CNT_ALL_ONES;
                  captured_in       = 1'b0;
                  underflow_in      = 1'b0;
                  prescale_count_in = '0;
                  channel_in        = req_channel;
                  push_job.status   = ST_NOT_READY;
               end else if (underflow_ff) begin
                  underflow_in    = 1'b0;
                  captured_in     = 1'b0;
                  saved_span_in   = '0;
                  push_job.status = ST_NO_EDGE;
               end else if (captured_ff) begin
                  underflow_in    = 1'b0;
                  captured_in     = 1'b0;
                  saved_span_in   = CNT_ALL_ONES - capture_ff;
                  push_job.status = ST_OK;
               end else begin
                  push_job.status = ST_NOT_READY;
               end
            end
            CMD_READ: begin
               push = 1'b1;
               if (req_channel != channel_ff) begin
                  push_job.status = ST_WRONG_CHANNEL;
               end else begin
                  push_job.status = ST_OK;
                  push_job.divide = 1'b1;
                  push_job.span   = saved_span_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_count_ff <= '0;
         down_counter_ff   <= CNT_ALL_ONES;
         capture_ff        <= CNT_ALL_ONES;
         previous_pin_ff   <= 1'b1;
         captured_ff       <= 1'b0;
         underflow_ff      <= 1'b0;
         saved_span_ff     <= '0;
         channel_ff        <= '0;
      end else begin
         prescale_count_ff <= prescale_count_in;
         down_counter_ff   <= down_counter_in;
         capture_ff        <= capture_in;
         previous_pin_ff   <= previous_pin_in;
         captured_ff       <= captured_in;
         underflow_ff      <= underflow_in;
         saved_span_ff     <= saved_span_in;
         channel_ff        <= channel_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/tcr_queue.sv
// Short job queue between the front and the back of the tachometer block.
// Depends on tcr_pkg for the job type and depth.
`default_nettype none

module tcr_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire tcr_pkg::job_type  push_job,
   output logic                   full,
   input  wire logic              pop,
   output logic                   pop_valid,
   output tcr_pkg::job_type       pop_job
);
   import tcr_pkg::*;

   localparam logic [QUEUE_PTR_WIDTH-1:0] LAST_PTR = QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1);
   localparam logic [QUEUE_CNT_WIDTH-1:0] DEPTH_CNT = QUEUE_CNT_WIDTH'(QUEUE_DEPTH);

   job_type                    entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0] count_ff, count_in;
   logic                       do_push, do_pop;

   assign full      = (count_ff == DEPTH_CNT);
   assign pop_valid = (count_ff != '0);
   assign pop_job   = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + QUEUE_PTR_WIDTH'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + QUEUE_PTR_WIDTH'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_WIDTH'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/tcr_back.sv
// Back part: turns queued jobs into results, with a bit-serial divider for RPM.
// Depends on tcr_pkg; reads jobs from tcr_queue and drives the result channel.
`default_nettype none

module tcr_back (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 job_valid,
   input  wire tcr_pkg::job_type                     job,
   output logic                                      pop,
   input  wire logic [tcr_pkg::CLOCK_HZ_WIDTH-1:0]   sample_clock_hz,
   input  wire logic [tcr_pkg::PULSES_WIDTH-1:0]     pulses_per_turn,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [tcr_pkg::STATUS_WIDTH-1:0]          rsp_status,
   output logic [tcr_pkg::RPM_WIDTH-1:0]             rsp_rpm
);
   import tcr_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL  = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic [STATUS_WIDTH-1:0] status_ff, status_in;
   count_type               span_ff, span_in;
   logic [NUM_WIDTH-1:0]    num_ff, num_in;
   logic [DEN_WIDTH-1:0]    den_ff, den_in;
   logic [DEN_WIDTH-1:0]    rem_ff, rem_in;
   logic [STEP_WIDTH-1:0]   step_ff, step_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_WIDTH-1:0] rsp_status_ff, rsp_status_in;
   logic [RPM_WIDTH-1:0]    rsp_rpm_ff, rsp_rpm_in;

   logic [PULSES_WIDTH-1:0] pulses_eff;
   logic [DEN_WIDTH:0]      rem_shift;
   logic [DEN_WIDTH:0]      rem_diff;
   logic                    out_free;
   logic [RPM_WIDTH-1:0]    rpm_sat;

   assign pulses_eff = (pulses_per_turn == '0) ? PULSES_WIDTH'(1) : pulses_per_turn;
   assign rem_shift  = {rem_ff, num_ff[NUM_WIDTH-1]};
   assign rem_diff   = rem_shift - {1'b0, den_ff};
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   // Quotients that do not fit the result width saturate.
   assign rpm_sat    = (num_ff[NUM_WIDTH-1:RPM_WIDTH] != '0) ? {RPM_WIDTH{1'b1}}
                                                              : num_ff[RPM_WIDTH-1:0];

   assign pop        = (state_ff == S_IDLE) && job_valid;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_rpm    = rsp_rpm_ff;

   always_comb begin
      state_in      = state_ff;
      status_in     = status_ff;
      span_in       = span_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_rpm_in    = rsp_rpm_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               status_in = job.status;
               span_in   = job.span;
               num_in    = '0;
               if (job.divide && job.span != '0) begin
                  state_in = S_MUL;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_MUL: begin
            num_in   = NUM_WIDTH'(sample_clock_hz) * NUM_WIDTH'(RPM_SECONDS);
            den_in   = DEN_WIDTH'(pulses_eff) * DEN_WIDTH'(span_ff);
            rem_in   = '0;
            step_in  = STEP_WIDTH'(NUM_WIDTH);
            state_in = S_DIV;
         end
         S_DIV: begin
            // One restoring step: quotient bits shift into the dividend register.
            if (rem_shift >= {1'b0, den_ff}) begin
               rem_in = rem_diff[DEN_WIDTH-1:0];
               num_in = {num_ff[NUM_WIDTH-2:0], 1'b1};
            end else begin
               rem_in = rem_shift[DEN_WIDTH-1:0];
               num_in = {num_ff[NUM_WIDTH-2:0], 1'b0};
            end
            step_in = step_ff - STEP_WIDTH'(1);
            if (step_ff == STEP_WIDTH'(1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_rpm_in    = rpm_sat;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      span_ff       <= span_in;
      num_ff        <= num_in;
      den_ff        <= den_in;
      rem_ff        <= rem_in;
      step_ff       <= step_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rpm_ff    <= rsp_rpm_in;
   end

endmodule

`default_nettype wire

// File: rtl/core/tachometer_capture_rpm_top.sv
// Top level of the tachometer capture block with RPM read-out.
// Depends on tcr_pkg, tcr_front, tcr_queue and tcr_back.
`default_nettype none

// The block measures the period of a tach signal with a 16-bit down counter
// and turns it into revolutions per minute. Tick transfers (command 0) carry
// the sampled pin level; a falling edge latches the counter, and a counter
// underflow marks that no edge was seen. A fetch transfer (command 1)
// validates the latest capture for the selected channel, and a read transfer
// (command 2) returns sample_clock_hz * 60 / (pulses_per_turn * span).
// Ticks produce no result; fetch and read produce exactly one result each.
// Ticks are taken one per cycle, as long as the two-entry job queue between
// the front and the back is not full; the input stall follows that queue.
// A fetch or a wrong-channel read passes through the job queue and the back
// part's done state to the result register. A valid read also runs through
// the one-bit-per-cycle restoring divider (a multiply step and 33 divide
// steps), and while it runs further ticks still flow into the front.
// Configuration must be written through the csr_ port while the block is idle;
// the block does not enforce this. A prescale_divide or pulses_per_turn of zero behaves as one.
module tachometer_capture_rpm_top (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [tcr_pkg::CMD_WIDTH-1:0]        req_command,
   input  wire logic                                 req_pin_level,
   input  wire logic [tcr_pkg::CHANNEL_WIDTH-1:0]    req_channel,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [tcr_pkg::STATUS_WIDTH-1:0]          rsp_status,
   output logic [tcr_pkg::RPM_WIDTH-1:0]             rsp_rpm,
   input  wire logic                                 csr_write_enable,
   input  wire logic [tcr_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [tcr_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import tcr_pkg::*;

   logic [PRESCALE_WIDTH-1:0] prescale_divide_ff;
   logic [CLOCK_HZ_WIDTH-1:0] sample_clock_hz_ff;
   logic [PULSES_WIDTH-1:0]   pulses_per_turn_ff;

   logic    push;
   job_type push_job;
   logic    queue_full;
   logic    pop;
   logic    job_valid;
   job_type job;

   // Configuration registers; writes to an index past the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_divide_ff <= PRESCALE_WIDTH'(1);
         sample_clock_hz_ff <= CLOCK_HZ_WIDTH'(32768);
         pulses_per_turn_ff <= PULSES_WIDTH'(1);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PRESCALE_DIVIDE: prescale_divide_ff <= csr_wdata[PRESCALE_WIDTH-1:0];
            CSR_SAMPLE_CLOCK_HZ: sample_clock_hz_ff <= csr_wdata[CLOCK_HZ_WIDTH-1:0];
            CSR_PULSES_PER_TURN: pulses_per_turn_ff <= csr_wdata[PULSES_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   // The front owns the capture state and turns fetch and read into jobs.
   tcr_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_pin_level   (req_pin_level),
      .req_channel     (req_channel),
      .prescale_divide (prescale_divide_ff),
      .queue_full      (queue_full),
      .push            (push),
      .push_job        (push_job)
   );

   tcr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (job_valid),
      .pop_job   (job)
   );

   // The back runs the divider and holds the result register.
   tcr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (job_valid),
      .job             (job),
      .pop             (pop),
      .sample_clock_hz (sample_clock_hz_ff),
      .pulses_per_turn (pulses_per_turn_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_rpm         (rsp_rpm)
   );

endmodule

`default_nettype wire

// File: rtl/core/tcr_checker.sv
// Port-level checks of the tachometer capture block, and the bind that attaches them.
// Depends on tcr_pkg and on the ports of tachometer_capture_rpm_top.
`default_nettype none

module tcr_checker (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   input  wire logic                                 req_stall,
   input  wire logic [tcr_pkg::CMD_WIDTH-1:0]        req_command,
   input  wire logic                                 rsp_valid,
   input  wire logic                                 rsp_stall,
   input  wire logic [tcr_pkg::STATUS_WIDTH-1:0]     rsp_status,
   input  wire logic [tcr_pkg::RPM_WIDTH-1:0]        rsp_rpm
);
   import tcr_pkg::*;

   // A stalled result stays put until its transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_rpm))
      else $error("result changed while stalled");

   // Only a successful read carries a nonzero rpm.
   a_rpm_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_rpm == '0)
      else $error("nonzero rpm with a failing status");

   // The input stalls only after a fetch or read filled the job queue.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |->
         $past(req_valid && !req_stall && (req_command == CMD_FETCH || req_command == CMD_READ)))
      else $error("input stall rose without a queued job");

   // Reset leaves no result pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind tachometer_capture_rpm_top tcr_checker u_tcr_checker (.*);

`default_nettype wire

// File: dv/tb_tachometer_capture_rpm_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for tachometer_capture_rpm_top: capture, fetch and RPM read-out.
// Depends on tcr_pkg and the RTL of the block; it keeps its own model of the counter state.

module tb_tachometer_capture_rpm_top;
   import tcr_pkg::*;

   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int SETTLE_CYCLES    = 40;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DIRECTED_COUNT   = 25;
   localparam int PHASE_COUNT      = 6;
   localparam int PHASE_TRANSFERS  = 110;
   localparam int PHASE_READINGS   = 12;
   localparam int HALF_PERIOD_CAP  = 8;
   localparam int MAX_REPORTS      = 10;
   localparam bit CHECK_TYPED      = 1'b1;
   localparam bit CHECK_MODEL      = 1'b0;

   // One result of a fetch or a read, as the block reports it.
   typedef struct packed {
      logic [STATUS_WIDTH-1:0] status;
      logic [RPM_WIDTH-1:0]    rpm;
   } tach_reading_type;

   // One row of the directed stimulus. Rows marked CHECK_TYPED carry their
   // own expected result; the others are checked against the model.
   typedef struct packed {
      logic [CMD_WIDTH-1:0]     command;
      logic                     pin;
      logic [CHANNEL_WIDTH-1:0] channel;
      bit                       typed;
      logic [STATUS_WIDTH-1:0]  status;
      logic [RPM_WIDTH-1:0]     rpm;
   } directed_row_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [CMD_WIDTH-1:0]       req_command;
   logic                       req_pin_level;
   logic [CHANNEL_WIDTH-1:0]   req_channel;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [STATUS_WIDTH-1:0]    rsp_status;
   logic [RPM_WIDTH-1:0]       rsp_rpm;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   tachometer_capture_rpm_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_pin_level    (req_pin_level),
      .req_channel      (req_channel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_rpm          (rsp_rpm),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Model of the block: configuration, capture state and the RPM formula.
   // ------------------------------------------------------------------
   logic [PRESCALE_WIDTH-1:0] cfg_prescale;
   logic [CLOCK_HZ_WIDTH-1:0] cfg_clock_hz;
   logic [PULSES_WIDTH-1:0]   cfg_pulses;

   logic [7:0]                tick_phase;
   count_type                 down_count;
   count_type                 captured_count;
   count_type                 span;
   logic                      last_pin;
   logic                      edge_seen;
   logic                      no_edge;
   logic [CHANNEL_WIDTH-1:0]  active_chan;

   // Counter and capture go back to all ones and both flags clear; the
   // saved span and the previous pin level survive a restart.
   function automatic void restart_capture();
      down_count     = CNT_ALL_ONES;
      captured_count = CNT_ALL_ONES;
      edge_seen      = 1'b0;
      no_edge        = 1'b0;
      tick_phase     = '0;
   endfunction

   function automatic void reset_tach_model();
      cfg_prescale = 8'd1;
      cfg_clock_hz = 27'd32768;
      cfg_pulses   = 8'd1;
      restart_capture();
      last_pin     = 1'b1;
      span         = '0;
      active_chan  = '0;
   endfunction

   // Applies one accepted transfer to the model. Returns 1 when the transfer
   // produces a result, which is then left in reading.
   function automatic bit next_tach_reading(input logic [CMD_WIDTH-1:0] cmd,
                                            input logic pin,
                                            input logic [CHANNEL_WIDTH-1:0] chan,
                                            output tach_reading_type reading);
      logic [63:0] numerator;
      logic [63:0] denominator;
      logic [63:0] quotient;
      logic [7:0]  divide_by;
      logic [7:0]  pulses;

      reading = '0;
      reading.status = ST_OK;
      case (cmd)
         CMD_TICK: begin
            divide_by = (cfg_prescale == 8'd0) ? 8'd1 : cfg_prescale;
            if (last_pin && !pin) begin
               // A falling edge latches the counter; no decrement this tick.
               captured_count = down_count;
               down_count     = CNT_ALL_ONES;
               edge_seen      = 1'b1;
            end else begin
               tick_phase = tick_phase + 8'd1;
               if (tick_phase >= divide_by) begin
                  tick_phase = '0;
                  if (down_count == '0) begin
                     no_edge    = 1'b1;
                     down_count = CNT_ALL_ONES;
                  end else begin
                     down_count = down_count - 16'd1;
                  end
               end
            end
            last_pin = pin;
            return 1'b0;
         end
         CMD_FETCH: begin
            if (int'(chan) >= NUM_CHANNELS) begin
               reading.status = ST_WRONG_CHANNEL;
            end else if (chan != active_chan) begin
               restart_capture();
               active_chan    = chan;
               reading.status = ST_NOT_READY;
            end else if (no_edge) begin
               no_edge        = 1'b0;
               edge_seen      = 1'b0;
               span           = '0;
               reading.status = ST_NO_EDGE;
            end else if (edge_seen) begin
               no_edge   = 1'b0;
               edge_seen = 1'b0;
               span      = CNT_ALL_ONES - captured_count;
            end else begin
               reading.status = ST_NOT_READY;
            end
            return 1'b1;
         end
         CMD_READ: begin
            if (chan != active_chan) begin
               reading.status = ST_WRONG_CHANNEL;
            end else if (span != '0) begin
               pulses      = (cfg_pulses == 8'd0) ? 8'd1 : cfg_pulses;
               numerator   = 64'(cfg_clock_hz) * 64'(RPM_SECONDS);
               denominator = 64'(pulses) * 64'(span);
               quotient    = numerator / denominator;
               reading.rpm = (quotient > 64'hFFFF_FFFF) ? '1 : quotient[31:0];
            end
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Scoreboard state and run statistics.
   // ------------------------------------------------------------------
   tach_reading_type readings_due [$];
   int            failures        = 0;
   int            transfers_sent  = 0;
   int            ticks_sent      = 0;
   int            readings_queued = 0;
   int            readings_checked = 0;
   int            saturated_seen  = 0;
   int            status_seen [4] = '{0, 0, 0, 0};
   int            quiet_cycles    = 0;

   // Shared between the stimulus process and the result-side stall process.
   bit            gaps_on           = 1'b0;
   bit            long_hold_request = 1'b0;

   task automatic report_failure(input string what);
      failures++;
      if (failures <= MAX_REPORTS) $display("ERROR: %s", what);
   endtask

   // Result side: compare every accepted result with the oldest expectation.
   // The watchdog sits in the same process and counts cycles in which no
   // transfer happens on either channel.
   always @(posedge clock) begin
      tach_reading_type due;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (readings_due.size() == 0) begin
               report_failure($sformatf("result with nothing pending: status %0d rpm %0d",
                                        rsp_status, rsp_rpm));
            end else begin
               due = readings_due.pop_front();
               readings_checked++;
               status_seen[due.status]++;
               if (due.status == ST_OK && due.rpm == '1) saturated_seen++;
               if (rsp_status !== due.status || rsp_rpm !== due.rpm) begin
                  report_failure($sformatf(
                     "result %0d: expected status %0d rpm %0d, got status %0d rpm %0d",
                     readings_checked, due.status, due.rpm, rsp_status, rsp_rpm));
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_tachometer_capture_rpm_top NOT OK");
            $finish;
         end
      end
   end

   // Result-side back-pressure. Normally short random bursts; on request one
   // long hold-off so that the job queue fills and the input stalls.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic logic [CHANNEL_WIDTH-1:0] random_channel();
      return CHANNEL_WIDTH'($urandom_range(0, NUM_CHANNELS - 1));
   endfunction

   // Offers one transfer at a falling edge and holds it until it is taken.
   // The model is stepped at the accepting edge. Valid stays high into the
   // next transfer unless a random gap is inserted.
   task automatic offer_transfer(input logic [CMD_WIDTH-1:0] cmd,
                                 input logic pin,
                                 input logic [CHANNEL_WIDTH-1:0] chan,
                                 input bit typed = CHECK_MODEL,
                                 input tach_reading_type typed_reading = '0);
      tach_reading_type predicted;
      bit               has_reading;

      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_pin_level <= pin;
      req_channel   <= chan;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      has_reading = next_tach_reading(cmd, pin, chan, predicted);
      if (has_reading) begin
         readings_due.push_back(typed ? typed_reading : predicted);
         readings_queued++;
      end
      if (cmd != CMD_UNUSED) transfers_sent++;
      if (cmd == CMD_TICK) ticks_sent++;
      @(negedge clock);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
   endtask

   // Stops offering, waits for every pending result and then leaves a few
   // quiet cycles so the result side is idle before anything else happens.
   task automatic drain_readings();
      req_valid <= 1'b0;
      while (readings_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic program_settings(input logic [PRESCALE_WIDTH-1:0] prescale,
                                   input logic [CLOCK_HZ_WIDTH-1:0] clock_hz,
                                   input logic [PULSES_WIDTH-1:0] pulses);
      drain_readings();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_PRESCALE_DIVIDE;
      csr_wdata        <= CSR_DATA_WIDTH'(prescale);
      @(negedge clock);
      csr_index        <= CSR_SAMPLE_CLOCK_HZ;
      csr_wdata        <= clock_hz;
      @(negedge clock);
      csr_index        <= CSR_PULSES_PER_TURN;
      csr_wdata        <= CSR_DATA_WIDTH'(pulses);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      cfg_prescale = prescale;
      cfg_clock_hz = clock_hz;
      cfg_pulses   = pulses;
   endtask

   // Random traffic for one register setting. Most of it is well-formed:
   // a few pin periods so that the counter captures, then a fetch and one
   // or two reads, mostly on the active channel. The rest is loose noise,
   // including the unused command and channel switches. Pin half periods
   // are kept short to hold the run compact, so a large prescaler gives
   // small spans and large RPM values.
   task automatic run_random_phase(input bit no_idling);
      int start_sent;
      int start_readings;
      int divide_by;
      int base;
      int half_cap;

      start_sent     = transfers_sent;
      start_readings = readings_queued;
      while ((transfers_sent - start_sent) < PHASE_TRANSFERS ||
             (readings_queued - start_readings) < PHASE_READINGS) begin
         gaps_on = !no_idling && ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 4) != 0) begin
            divide_by = (cfg_prescale == 8'd0) ? 1 : int'(cfg_prescale);
            base      = ($urandom_range(0, 3) == 0) ? 60 : 3;
            half_cap  = (base * divide_by > HALF_PERIOD_CAP) ? HALF_PERIOD_CAP
                                                              : base * divide_by;
            if ($urandom_range(0, 7) != 0) begin
               repeat ($urandom_range(1, 3)) begin
                  repeat ($urandom_range(1, half_cap))
                     offer_transfer(CMD_TICK, 1'b1, random_channel());
                  repeat ($urandom_range(1, half_cap))
                     offer_transfer(CMD_TICK, 1'b0, random_channel());
               end
            end
            offer_transfer(CMD_FETCH, 1'($urandom_range(0, 1)),
                           ($urandom_range(0, 7) == 0) ? random_channel() : active_chan);
            repeat ($urandom_range(1, 2))
               offer_transfer(CMD_READ, 1'($urandom_range(0, 1)),
                              ($urandom_range(0, 5) == 0) ? random_channel() : active_chan);
         end else begin
            repeat ($urandom_range(1, 6))
               offer_transfer(CMD_WIDTH'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                              random_channel());
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus: directed table, then random phases.
   // ------------------------------------------------------------------
   initial begin
      directed_row_type directed_rows [DIRECTED_COUNT];
      directed_row_type row;
      tach_reading_type typed_reading;
      logic [PRESCALE_WIDTH-1:0] phase_prescale;
      logic [CLOCK_HZ_WIDTH-1:0] phase_clock_hz;
      logic [PULSES_WIDTH-1:0]   phase_pulses;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_command      = CMD_TICK;
      req_pin_level    = 1'b0;
      req_channel      = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_PRESCALE_DIVIDE;
      csr_wdata        = '0;

      // The directed part runs on the reset configuration. It walks the
      // reset state, the zero-span read, short captures, repeated fetches,
      // channel changes in both directions, wrong-channel reads, the unused
      // command and both extremes of the channel field.
      directed_rows = '{
         '{CMD_READ,   1'b0, 3'd0, CHECK_TYPED, ST_OK,            32'd0},
         '{CMD_READ,   1'b1, 3'd5, CHECK_TYPED, ST_WRONG_CHANNEL, 32'd0},
         '{CMD_FETCH,  1'b0, 3'd0, CHECK_TYPED, ST_NOT_READY,     32'd0},
         '{CMD_UNUSED, 1'b1, 3'd7, CHECK_MODEL, ST_OK,            32'd0},
         '{CMD_TICK,   1'b0, 3'd0, CHECK_MODEL, ST_OK,            32'd0},
         '{CMD_FETCH,  1'b0, 3'd0, CHECK_MODEL, ST_OK,            32'd0},
         '{CMD_READ,   1'b0, 3'd0, CHECK_MODEL, ST_OK,            32'd0},
         '{CMD_TICK,   1'b1, 3'd7, CHECK_MODEL, ST_OK,            32'd0},
         '{CMD_TICK,   1'b1, 3'd0, CHECK_MODEL, ST_OK,            32'd0},
         '{CMD_TICK,   1'b1, 3'd5, CHECK_MODEL, ST_OK,            32'd0},
         '{CMD_TICK,   1'b0, 3'd2, CHECK_MODEL, ST_OK,            32'd0},
         '{CMD_FETCH,  1'b1, 3'd0, CHECK_MODEL, ST_OK,            32'd0},
         '{CMD_READ,   1'b0, 3'd0, CHECK_MODEL, ST_OK,            32'd0},
         '{CMD_FETCH,  1'b0, 3'd0, CHECK_TYPED, ST_NOT_READY,     32'd0},
         '{CMD_READ,   1'b1, 3'd0, CHECK_MODEL, ST_OK,            32'd0},
         '{CMD_FETCH,  1'b0, 3'd7, CHECK_TYPED, ST_NOT_READY,     32'd0},
         '{CMD_READ,   1'b0, 3'd0, CHECK_TYPED, ST_WRONG_CHANNEL, 32'd0},
         '{CMD_READ,   1'b0, 3'd7, CHECK_MODEL, ST_OK,            32'd0},
         '{CMD_TICK,   1'b1, 3'd3, CHECK_MODEL, ST_OK,            32'd0},
         '{CMD_TICK,   1'b0, 3'd4, CHECK_MODEL, ST_OK,            32'd0},
         '{CMD_FETCH,  1'b1, 3'd7, CHECK_MODEL, ST_OK,            32'd0},
         '{CMD_READ,   1'b1, 3'd7, CHECK_MODEL, ST_OK,            32'd0},
         '{CMD_UNUSED, 1'b0, 3'd0, CHECK_MODEL, ST_OK,            32'd0},
         '{CMD_FETCH,  1'b0, 3'd0, CHECK_TYPED, ST_NOT_READY,     32'd0},
         '{CMD_READ,   1'b0, 3'd7, CHECK_TYPED, ST_WRONG_CHANNEL, 32'd0}
      };

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      reset_tach_model();

      gaps_on = 1'b1;
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         row = directed_rows[i];
         typed_reading.status = row.status;
         typed_reading.rpm    = row.rpm;
         offer_transfer(row.command, row.pin, row.channel, row.typed, typed_reading);
      end

      // Random phases, one per register setting. The settings cover zero
      // registers (treated as one), the top of every register field, an
      // RPM large enough to saturate, and a random mix. The last phase runs
      // with no idling on either side.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin
               phase_prescale = 8'd0;
               phase_clock_hz = 27'd1;
               phase_pulses   = 8'd0;
            end
            1: begin
               phase_prescale = 8'd255;
               phase_clock_hz = 27'h7FF_FFFF;
               phase_pulses   = 8'd255;
            end
            2: begin
               phase_prescale = 8'd1;
               phase_clock_hz = 27'd100_000_000;
               phase_pulses   = 8'd1;
            end
            3: begin
               phase_prescale = 8'd3;
               phase_clock_hz = 27'd32768;
               phase_pulses   = 8'd4;
            end
            4: begin
               phase_prescale = 8'($urandom_range(1, 255));
               phase_clock_hz = 27'($urandom_range(1, 100_000_000));
               phase_pulses   = 8'($urandom_range(1, 255));
            end
            default: begin
               phase_prescale = 8'd2;
               phase_clock_hz = 27'd1_000_000;
               phase_pulses   = 8'd7;
            end
         endcase
         program_settings(phase_prescale, phase_clock_hz, phase_pulses);

         if (phase == 2) begin
            // Hold the result side for a long stretch while fetches and
            // reads keep coming, so the job queue fills and the input
            // stalls; afterwards stop and let every result come out.
            gaps_on = 1'b0;
            long_hold_request = 1'b1;
            repeat (12) begin
               offer_transfer(CMD_TICK, 1'($urandom_range(0, 1)), random_channel());
               offer_transfer(CMD_FETCH, 1'b0, active_chan);
               offer_transfer(CMD_READ, 1'b1, active_chan);
            end
            drain_readings();
         end

         run_random_phase(phase == PHASE_COUNT - 1);
      end

      gaps_on = 1'b0;
      drain_readings();

      $display("Covered %0d transfers (%0d ticks) and %0d checked results over %0d settings,",
               transfers_sent, ticks_sent, readings_checked, PHASE_COUNT + 1);
      $display("with %0d no-edge, %0d wrong-channel and %0d saturated results.",
               status_seen[ST_NO_EDGE], status_seen[ST_WRONG_CHANNEL], saturated_seen);
      if (failures == 0) begin
         $display("tb_tachometer_capture_rpm_top OK");
      end else begin
         $display("tb_tachometer_capture_rpm_top NOT OK");
      end
      $finish;
   end

endmodule
